FILE: sv/rgba_box_downsample_2x2_defines.svh
// Assertion macros for the downsampler modules; only rbd_raster uses them.
`ifndef RGBA_BOX_DOWNSAMPLE_2X2_DEFINES_SVH
`define RGBA_BOX_DOWNSAMPLE_2X2_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RBD_ASSERT_SAME(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error("rbd assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define RBD_ASSERT_NEXT(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error("rbd assertion failed");

`endif

FILE: sv/rbd_pkg.sv
package rbd_pkg;

  localparam int unsigned MAX_WIDTH  = 4096;
  localparam int unsigned MAX_HEIGHT = 4096;

  localparam int unsigned COL_W      = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_W      = $clog2(MAX_HEIGHT);
  localparam int unsigned WIDTH_W    = COL_W + 1;
  localparam int unsigned HEIGHT_W   = ROW_W + 1;
  localparam int unsigned PAIR_W     = COL_W - 1;
  localparam int unsigned PAIR_DEPTH = MAX_WIDTH / 2;

  localparam int unsigned SIZE_W  = 13;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned TEXEL_W = 32;
  localparam int unsigned LIN_W   = 17;
  localparam int unsigned CFG_W   = 2;

  typedef enum logic [CFG_W-1:0] {
    REG_SOURCE_WIDTH  = 2'd0,
    REG_SOURCE_HEIGHT = 2'd1,
    REG_SRGB_MODE     = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic [TEXEL_W-1:0] cur;
    logic [TEXEL_W-1:0] left;
    logic               w1;
    logic               h1;
    logic               srgb;
    logic               done;
  } rbd_item_t;

  typedef logic [LIN_W-1:0] lut_t [256];

  function automatic longint unsigned q30_mul(input longint unsigned a,
                                              input longint unsigned b);
    return (a * b) >> 30;
  endfunction

  // Code n is in units of 1/510; the result is linear light in Q1.16.
  function automatic logic [LIN_W-1:0] curve_decode(input int unsigned n);
    longint unsigned a;
    longint unsigned t30;
    longint unsigned t2;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    longint unsigned r2;
    longint unsigned p;
    if (n <= 20) begin
      return LIN_W'((longint'(n) * 6553600 + 329460) / 658920);
    end
    a = longint'(n) * 1000 + 28050;
    t30 = (a << 30) / 538050;
    if (t30 > (64'd1 << 30)) t30 = 64'd1 << 30;
    t2 = q30_mul(t30, t30);
    lo = 0;
    hi = 64'd1 << 30;
    // Fifth root of t squared by bisection; 31 halvings cover the range.
    for (int i = 0; i < 32; i++) begin
      if (lo < hi) begin
        mid = lo + ((hi - lo + 1) >> 1);
        r2 = q30_mul(mid, mid);
        if (q30_mul(q30_mul(r2, r2), mid) <= t2) lo = mid;
        else hi = mid - 1;
      end
    end
    p = q30_mul(t2, lo);
    return LIN_W'((p + 8192) >> 14);
  endfunction

  function automatic lut_t build_decode();
    lut_t t;
    for (int unsigned v = 0; v < 256; v++) t[v] = curve_decode(2 * v);
    return t;
  endfunction

  function automatic lut_t build_thresh();
    lut_t t;
    t[0] = '0;
    for (int unsigned k = 1; k < 256; k++) t[k] = curve_decode(2 * k - 1);
    return t;
  endfunction

  localparam lut_t DECODE_LUT = build_decode();
  localparam lut_t THRESH_LUT = build_thresh();

  // Two bits of the binary search for the encoded byte, top bit at hi.
  function automatic logic [BYTE_W-1:0] enc_step(input logic [BYTE_W-1:0] idx,
                                                 input logic [LIN_W-1:0] avg,
                                                 input int unsigned hi);
    logic [BYTE_W-1:0] r;
    logic [BYTE_W-1:0] a;
    r = idx;
    a = r | BYTE_W'(1 << hi);
    if (THRESH_LUT[a] <= avg) r = a;
    a = r | BYTE_W'(1 << (hi - 1));
    if (THRESH_LUT[a] <= avg) r = a;
    return r;
  endfunction

endpackage

FILE: sv/rbd_row_store.sv
module rbd_row_store (
  input  logic                         clk,
  input  logic                         we,
  input  logic [rbd_pkg::PAIR_W-1:0]   waddr,
  input  logic [2*rbd_pkg::TEXEL_W-1:0] wdata,
  input  logic                         re,
  input  logic [rbd_pkg::PAIR_W-1:0]   raddr,
  output logic [2*rbd_pkg::TEXEL_W-1:0] rdata
);

  // Each entry holds one column pair of the last even row: left in the low half.
  logic [2*rbd_pkg::TEXEL_W-1:0] mem [rbd_pkg::PAIR_DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (re) rdata <= mem[raddr];
  end

endmodule

FILE: sv/rbd_raster.sv
`include "rgba_box_downsample_2x2_defines.svh"

module rbd_raster (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  input  logic [rbd_pkg::CFG_W-1:0]     cfg_index,
  input  logic [rbd_pkg::SIZE_W-1:0]    cfg_data,
  input  logic                          in_valid,
  input  logic [rbd_pkg::TEXEL_W-1:0]   texel,
  input  logic                          item_ready,
  output logic                          item_valid,
  output rbd_pkg::rbd_item_t            item,
  output logic                          mem_we,
  output logic [rbd_pkg::PAIR_W-1:0]    mem_waddr,
  output logic [2*rbd_pkg::TEXEL_W-1:0] mem_wdata,
  output logic [rbd_pkg::PAIR_W-1:0]    mem_raddr
);

  logic [rbd_pkg::SIZE_W-1:0]   src_w;
  logic [rbd_pkg::SIZE_W-1:0]   src_h;
  logic                         srgb;
  logic [rbd_pkg::COL_W-1:0]    col;
  logic [rbd_pkg::ROW_W-1:0]    row;
  logic [rbd_pkg::TEXEL_W-1:0]  left;

  logic [rbd_pkg::WIDTH_W-1:0]  w_eff;
  logic [rbd_pkg::HEIGHT_W-1:0] h_eff;
  logic                         w1;
  logic                         h1;
  logic [rbd_pkg::PAIR_W-1:0]   ow_m1;
  logic [rbd_pkg::ROW_W-2:0]    oh_m1;
  logic                         last_col;
  logic                         last_row;
  logic                         produce;
  logic                         accept;

  always_comb begin
    if (src_w == '0) w_eff = rbd_pkg::WIDTH_W'(1);
    else if (32'(src_w) > rbd_pkg::MAX_WIDTH) w_eff = rbd_pkg::WIDTH_W'(rbd_pkg::MAX_WIDTH);
    else w_eff = rbd_pkg::WIDTH_W'(src_w);
    if (src_h == '0) h_eff = rbd_pkg::HEIGHT_W'(1);
    else if (32'(src_h) > rbd_pkg::MAX_HEIGHT) h_eff = rbd_pkg::HEIGHT_W'(rbd_pkg::MAX_HEIGHT);
    else h_eff = rbd_pkg::HEIGHT_W'(src_h);
  end

  assign w1       = (w_eff == rbd_pkg::WIDTH_W'(1));
  assign h1       = (h_eff == rbd_pkg::HEIGHT_W'(1));
  assign ow_m1    = w1 ? '0 : rbd_pkg::PAIR_W'((w_eff >> 1) - rbd_pkg::WIDTH_W'(1));
  assign oh_m1    = h1 ? '0 : (rbd_pkg::ROW_W-1)'((h_eff >> 1) - rbd_pkg::HEIGHT_W'(1));
  assign last_col = ({1'b0, col} == w_eff - rbd_pkg::WIDTH_W'(1));
  assign last_row = ({1'b0, row} == h_eff - rbd_pkg::HEIGHT_W'(1));
  assign produce  = (w1 || col[0]) && (h1 || row[0]);
  assign accept   = in_valid && item_ready;

  assign item_valid = accept && produce;
  assign item.cur   = texel;
  assign item.left  = left;
  assign item.w1    = w1;
  assign item.h1    = h1;
  assign item.srgb  = srgb;
  assign item.done  = (row[rbd_pkg::ROW_W-1:1] == oh_m1) &&
                      (col[rbd_pkg::COL_W-1:1] == ow_m1);

  // An even row is kept as column pairs: the pair is written on its odd column,
  // or at once when the level is a single column wide.
  assign mem_we    = accept && !h1 && !row[0] && (col[0] || w1);
  assign mem_waddr = col[rbd_pkg::COL_W-1:1];
  assign mem_wdata = w1 ? {texel, texel} : {texel, left};
  assign mem_raddr = col[rbd_pkg::COL_W-1:1];

  always_ff @(posedge clk) begin
    if (rst) begin
      src_w <= rbd_pkg::SIZE_W'(1);
      src_h <= rbd_pkg::SIZE_W'(1);
      srgb  <= 1'b0;
      col   <= '0;
      row   <= '0;
      left  <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        rbd_pkg::REG_SOURCE_WIDTH: begin
          src_w <= cfg_data;
          col   <= '0;
          row   <= '0;
          left  <= '0;
        end
        rbd_pkg::REG_SOURCE_HEIGHT: begin
          src_h <= cfg_data;
          col   <= '0;
          row   <= '0;
          left  <= '0;
        end
        rbd_pkg::REG_SRGB_MODE: begin
          srgb <= cfg_data[0];
        end
        default: begin
        end
      endcase
    end else if (accept) begin
      if (!col[0]) left <= texel;
      if (last_col) begin
        col <= '0;
        row <= last_row ? '0 : row + rbd_pkg::ROW_W'(1);
      end else begin
        col <= col + rbd_pkg::COL_W'(1);
      end
    end
  end

  `RBD_ASSERT_SAME(a_col_in_range, clk, rst, 1'b1, {1'b0, col} < w_eff)
  `RBD_ASSERT_SAME(a_row_in_range, clk, rst, 1'b1, {1'b0, row} < h_eff)
  `RBD_ASSERT_SAME(a_no_result_on_store_write, clk, rst, mem_we, !produce)
  `RBD_ASSERT_NEXT(a_wrap_at_line_end, clk, rst, accept && last_col && !cfg_valid, col == '0)

endmodule

FILE: sv/rbd_filter.sv
module rbd_filter (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  input  rbd_pkg::rbd_item_t            item,
  output logic                          item_ready,
  input  logic [2*rbd_pkg::TEXEL_W-1:0] row_pair,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [rbd_pkg::BYTE_W-1:0]    red_out,
  output logic [rbd_pkg::BYTE_W-1:0]    green_out,
  output logic [rbd_pkg::BYTE_W-1:0]    blue_out,
  output logic [rbd_pkg::BYTE_W-1:0]    alpha_out,
  output logic                          level_done
);

  logic v   [1:6];
  logic rdy [1:6];

  rbd_pkg::rbd_item_t it1;

  logic [rbd_pkg::LIN_W-1:0]  avg  [2:5][4];
  logic                       lin  [2:5][4];
  logic [rbd_pkg::BYTE_W-1:0] idx  [3:5][4];
  logic                       done [2:5];

  logic [rbd_pkg::TEXEL_W-1:0] taps [4];
  logic [rbd_pkg::LIN_W-1:0]   avg_c [4];
  logic                        lin_c [4];

  always_comb begin
    rdy[6] = !v[6] || !out_stall;
    for (int s = 5; s >= 1; s--) rdy[s] = !v[s] || rdy[s+1];
  end
  assign item_ready = rdy[1];

  // Taps in order top-left, top-right, bottom-left, bottom-right.
  always_comb begin
    logic [rbd_pkg::TEXEL_W-1:0] bl;
    logic [rbd_pkg::LIN_W+1:0]   sum;
    logic [rbd_pkg::BYTE_W-1:0]  b;
    bl = it1.w1 ? it1.cur : it1.left;
    taps[0] = it1.h1 ? bl : row_pair[rbd_pkg::TEXEL_W-1:0];
    taps[1] = it1.h1 ? it1.cur : row_pair[2*rbd_pkg::TEXEL_W-1:rbd_pkg::TEXEL_W];
    taps[2] = bl;
    taps[3] = it1.cur;
    for (int ch = 0; ch < 4; ch++) begin
      lin_c[ch] = (ch < 3) && it1.srgb;
      sum = '0;
      for (int t = 0; t < 4; t++) begin
        b = taps[t][ch*rbd_pkg::BYTE_W +: rbd_pkg::BYTE_W];
        sum = sum + (lin_c[ch] ? (rbd_pkg::LIN_W+2)'(rbd_pkg::DECODE_LUT[b])
                               : (rbd_pkg::LIN_W+2)'(b));
      end
      avg_c[ch] = rbd_pkg::LIN_W'((sum + (rbd_pkg::LIN_W+2)'(2)) >> 2);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 1; s <= 6; s++) v[s] <= 1'b0;
    end else begin
      if (rdy[1]) v[1] <= item_valid;
      for (int s = 2; s <= 6; s++) begin
        if (rdy[s]) v[s] <= v[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) it1 <= item;
    if (rdy[2]) begin
      done[2] <= it1.done;
      for (int ch = 0; ch < 4; ch++) begin
        avg[2][ch] <= avg_c[ch];
        lin[2][ch] <= lin_c[ch];
      end
    end
    if (rdy[3]) begin
      done[3] <= done[2];
      for (int ch = 0; ch < 4; ch++) begin
        avg[3][ch] <= avg[2][ch];
        lin[3][ch] <= lin[2][ch];
        idx[3][ch] <= rbd_pkg::enc_step('0, avg[2][ch], 7);
      end
    end
    for (int s = 4; s <= 5; s++) begin
      if (rdy[s]) begin
        done[s] <= done[s-1];
        for (int ch = 0; ch < 4; ch++) begin
          avg[s][ch] <= avg[s-1][ch];
          lin[s][ch] <= lin[s-1][ch];
          idx[s][ch] <= rbd_pkg::enc_step(idx[s-1][ch], avg[s-1][ch], 9 - 2 * (s - 2));
        end
      end
    end
    if (rdy[6]) begin
      level_done <= done[5];
      red_out    <= lin[5][0] ? rbd_pkg::enc_step(idx[5][0], avg[5][0], 1)
                              : avg[5][0][rbd_pkg::BYTE_W-1:0];
      green_out  <= lin[5][1] ? rbd_pkg::enc_step(idx[5][1], avg[5][1], 1)
                              : avg[5][1][rbd_pkg::BYTE_W-1:0];
      blue_out   <= lin[5][2] ? rbd_pkg::enc_step(idx[5][2], avg[5][2], 1)
                              : avg[5][2][rbd_pkg::BYTE_W-1:0];
      alpha_out  <= avg[5][3][rbd_pkg::BYTE_W-1:0];
    end
  end

  assign out_valid = v[6];

endmodule

FILE: sv/rgba_box_downsample_2x2.sv
// Streaming 2x2 box filter that builds one mip level from the level above.
// Source texels enter on the in channel in raster order, one item per cycle
// when in_valid is high and in_stall is low. Each 2x2 block gives one item
// on the out channel, taken when out_valid is high and out_stall is low;
// level_done marks the last texel of the output level. An odd last row or
// column is dropped, and a size of one reuses that texel along its axis.
// Size and mode are written over the cfg channel (index 0 width, 1 height,
// 2 sRGB mode); the user must write them only while the block is idle, since
// the block does not enforce it; a size write restarts the level.
// Throughput is one texel per cycle while in_stall is low: the previous even
// row sits in a line store of column pairs with one write and one registered
// read a cycle. The pipeline is the store read, the decode and average stage,
// and four stages of sRGB re-encoding, each resolving two bits of the output
// code. When the receiver stalls, results hold and the pipeline fills its
// empty stages before in_stall rises. Reset gives width and height one,
// linear mode and an empty pipeline; the line store needs no clearing.
module rgba_box_downsample_2x2 (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [rbd_pkg::CFG_W-1:0]  cfg_index,
  input  logic [rbd_pkg::SIZE_W-1:0] cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [rbd_pkg::BYTE_W-1:0] red_in,
  input  logic [rbd_pkg::BYTE_W-1:0] green_in,
  input  logic [rbd_pkg::BYTE_W-1:0] blue_in,
  input  logic [rbd_pkg::BYTE_W-1:0] alpha_in,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [rbd_pkg::BYTE_W-1:0] red_out,
  output logic [rbd_pkg::BYTE_W-1:0] green_out,
  output logic [rbd_pkg::BYTE_W-1:0] blue_out,
  output logic [rbd_pkg::BYTE_W-1:0] alpha_out,
  output logic                       level_done
);

  logic                          item_valid;
  logic                          item_ready;
  rbd_pkg::rbd_item_t            item;
  logic                          mem_we;
  logic [rbd_pkg::PAIR_W-1:0]    mem_waddr;
  logic [2*rbd_pkg::TEXEL_W-1:0] mem_wdata;
  logic [rbd_pkg::PAIR_W-1:0]    mem_raddr;
  logic [2*rbd_pkg::TEXEL_W-1:0] mem_rdata;

  assign cfg_ready = 1'b1;
  assign in_stall  = !item_ready;

  rbd_raster u_raster (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .texel      ({alpha_in, blue_in, green_in, red_in}),
    .item_ready (item_ready),
    .item_valid (item_valid),
    .item       (item),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_raddr  (mem_raddr)
  );

  rbd_row_store u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (item_ready),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  rbd_filter u_filter (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .item_ready (item_ready),
    .row_pair   (mem_rdata),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .red_out    (red_out),
    .green_out  (green_out),
    .blue_out   (blue_out),
    .alpha_out  (alpha_out),
    .level_done (level_done)
  );

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam logic [rbd_pkg::CFG_W-1:0] REG_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 12;

  typedef struct packed {
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] g;
    logic [7:0] r;
  } texel_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
    logic       done;
  } mip_texel_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [rbd_pkg::CFG_W-1:0] cfg_index = '0;
  logic [rbd_pkg::SIZE_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] red_in = '0, green_in = '0, blue_in = '0, alpha_in = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] red_out, green_out, blue_out, alpha_out;
  logic level_done;

  rgba_box_downsample_2x2 u_top (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state, mirroring the block's registers.
  logic [16:0] lin_of_byte [256];
  logic [16:0] round_edge [256];
  int unsigned pr_width = 1, pr_height = 1;
  bit pr_srgb = 1'b0;
  int unsigned pr_col = 0, pr_row = 0;
  texel_t pr_left = '0;
  texel_t pr_row_store [rbd_pkg::MAX_WIDTH];

  mip_texel_t expected_texels [$];
  int errors = 0;
  int texels_sent = 0;
  int send_gap_pct = 10;
  int stall_pct = 45;
  bit accepted_any;

  function automatic longint unsigned mul_q30(longint unsigned x, longint unsigned y);
    return (x * y) >> 30;
  endfunction

  // Linear light (Q1.16) of code n/510 on the sRGB curve.
  function automatic logic [16:0] srgb_to_linear(int unsigned n);
    longint unsigned num, t, t_sq, lo, hi, mid, sq;
    if (n <= 20) return 17'((longint'(n) * 6553600 + 329460) / 658920);
    num = longint'(n) * 1000 + 28050;
    t = (num << 30) / 538050;
    if (t > (64'd1 << 30)) t = 64'd1 << 30;
    t_sq = mul_q30(t, t);
    lo = 0;
    hi = 64'd1 << 30;
    while (lo < hi) begin
      mid = lo + ((hi - lo + 1) >> 1);
      sq = mul_q30(mid, mid);
      if (mul_q30(mul_q30(sq, sq), mid) <= t_sq) lo = mid;
      else hi = mid - 1;
    end
    return 17'((mul_q30(t_sq, lo) + 8192) >> 14);
  endfunction

  function automatic logic [7:0] linear_to_srgb(logic [16:0] lin);
    int unsigned n;
    n = 0;
    for (int k = 1; k < 256; k++) if (round_edge[k] <= lin) n++;
    return 8'(n);
  endfunction

  function automatic logic [7:0] mean_of_four(logic [7:0] p0, logic [7:0] p1,
                                              logic [7:0] p2, logic [7:0] p3,
                                              bit in_linear);
    int unsigned sum;
    if (!in_linear) return 8'((p0 + p1 + p2 + p3 + 2) >> 2);
    sum = lin_of_byte[p0] + lin_of_byte[p1] + lin_of_byte[p2] + lin_of_byte[p3];
    return linear_to_srgb(17'((sum + 2) >> 2));
  endfunction

  function automatic int unsigned clamp_size(int unsigned v);
    if (v == 0) return 1;
    return (v > rbd_pkg::MAX_WIDTH) ? rbd_pkg::MAX_WIDTH : v;
  endfunction

  task automatic predict_texel(texel_t cur);
    int unsigned w, h, ow, oh, c, r, ic, il;
    texel_t tl, tr, bl;
    mip_texel_t res;
    w = clamp_size(pr_width);
    h = clamp_size(pr_height);
    ow = (w > 1) ? w / 2 : 1;
    oh = (h > 1) ? h / 2 : 1;
    c = (pr_col >= w) ? 0 : pr_col;
    r = (pr_row >= h) ? 0 : pr_row;
    if ((w == 1 || c[0]) && (h == 1 || r[0])) begin
      bl = (w == 1) ? cur : pr_left;
      tl = bl;
      tr = cur;
      if (h > 1) begin
        ic = (c < rbd_pkg::MAX_WIDTH) ? c : rbd_pkg::MAX_WIDTH - 1;
        il = (w == 1) ? ic : ((ic > 0) ? ic - 1 : 0);
        tl = pr_row_store[il];
        tr = pr_row_store[ic];
      end
      res.r = mean_of_four(tl.r, tr.r, bl.r, cur.r, pr_srgb);
      res.g = mean_of_four(tl.g, tr.g, bl.g, cur.g, pr_srgb);
      res.b = mean_of_four(tl.b, tr.b, bl.b, cur.b, pr_srgb);
      res.a = mean_of_four(tl.a, tr.a, bl.a, cur.a, 1'b0);
      res.done = ((r >> 1) == oh - 1) && ((c >> 1) == ow - 1);
      expected_texels.insert(expected_texels.size(), res);
    end
    if (h > 1 && !r[0] && c < rbd_pkg::MAX_WIDTH) pr_row_store[c] = cur;
    if (!c[0]) pr_left = cur;
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    pr_col = c;
    pr_row = r;
  endtask

  task automatic send_texel(texel_t t);
    @(negedge clk);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    red_in <= t.r;
    green_in <= t.g;
    blue_in <= t.b;
    alpha_in <= t.a;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_texel(t);
    texels_sent++;
  endtask

  // Lowers valid and lets every outstanding result arrive before a register write.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_texels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [rbd_pkg::CFG_W-1:0] idx, int unsigned value);
    settle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= rbd_pkg::SIZE_W'(value);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      rbd_pkg::REG_SOURCE_WIDTH, rbd_pkg::REG_SOURCE_HEIGHT: begin
        if (idx == rbd_pkg::REG_SOURCE_WIDTH) pr_width = value & 13'h1FFF;
        else pr_height = value & 13'h1FFF;
        pr_col = 0;
        pr_row = 0;
        pr_left = '0;
      end
      rbd_pkg::REG_SRGB_MODE: pr_srgb = value[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_level(int unsigned w, int unsigned h, bit srgb);
    write_reg(rbd_pkg::REG_SOURCE_WIDTH, w);
    write_reg(rbd_pkg::REG_SOURCE_HEIGHT, h);
    write_reg(rbd_pkg::REG_SRGB_MODE, srgb);
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(5))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic texel_t random_texel();
    return '{a: pick_byte(), b: pick_byte(), g: pick_byte(), r: pick_byte()};
  endfunction

  task automatic test_linear_extremes();
    set_level(2, 2, 1'b0);
    send_texel(32'hFFFF_FFFF);
    send_texel(32'hFFFF_FFFF);
    send_texel(32'hFFFF_FFFF);
    send_texel(32'h0000_0000);
    // A sum of two rounds up, a sum of one rounds down.
    send_texel(32'h0001_0201);
    send_texel(32'h0000_0001);
    send_texel(32'h0100_0000);
    send_texel(32'h0100_0000);
  endtask

  task automatic test_srgb_average();
    set_level(2, 2, 1'b1);
    send_texel(32'h80FF_00FF);
    send_texel(32'h8000_FF00);
    send_texel(32'h80FF_00FF);
    send_texel(32'h8000_FF00);
    // Mode change between levels takes effect on the next texel.
    write_reg(rbd_pkg::REG_SRGB_MODE, 0);
    repeat (4) send_texel(random_texel());
  endtask

  task automatic test_odd_and_unit_sizes();
    set_level(3, 3, 1'b1);
    repeat (9) send_texel(random_texel());
    set_level(1, 1, 1'b0);
    repeat (2) send_texel(random_texel());
    set_level(0, 0, 1'b1);
    repeat (2) send_texel(random_texel());
  endtask

  task automatic test_size_limits();
    set_level(8191, 1, 1'b0);
    repeat (6) send_texel(random_texel());
    set_level(1, 8191, 1'b1);
    repeat (6) send_texel(random_texel());
    // A write to an index that names no register must change nothing.
    set_level(4, 2, 1'b0);
    write_reg(REG_UNUSED, 13'h1555);
    repeat (8) send_texel(random_texel());
  endtask

  task automatic test_random_levels(int target);
    int stop_at, w, h, n;
    stop_at = texels_sent + target;
    while (texels_sent < stop_at) begin
      w = ($urandom_range(9) == 0) ? $urandom_range(40, 4096) : $urandom_range(1, 9);
      h = $urandom_range(1, 7);
      set_level(w, h, $urandom_range(1));
      // Mostly whole levels, sometimes two in a row or a level cut short.
      n = clamp_size(w) * h;
      if (n > 120) n = $urandom_range(10, 120);
      else if ($urandom_range(3) == 0) n = 2 * n;
      else if ($urandom_range(4) == 0) n = $urandom_range(1, n);
      repeat (n) send_texel(random_texel());
    end
  endtask

  always @(negedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  always @(posedge clk) begin
    mip_texel_t want;
    logic [7:0] got_f [5];
    logic [7:0] want_f [5];
    string names [5];
    if (!rst && out_valid && !out_stall) begin
      if (expected_texels.size() == 0) begin
        $display("%0t: unexpected result r=%0d g=%0d b=%0d a=%0d done=%0d", $time,
                 red_out, green_out, blue_out, alpha_out, level_done);
        errors++;
      end else begin
        want = expected_texels.pop_front();
        names = '{"red", "green", "blue", "alpha", "level_done"};
        want_f = '{want.r, want.g, want.b, want.a, 8'(want.done)};
        got_f = '{red_out, green_out, blue_out, alpha_out, 8'(level_done)};
        for (int i = 0; i < 5; i++) begin
          if (want_f[i] !== got_f[i]) begin
            $display("%0t: %s expected %0d got %0d", $time, names[i], want_f[i], got_f[i]);
            errors++;
          end
        end
      end
    end
  end

  int idle_cycles = 0;
  always @(posedge clk) begin
    accepted_any = (in_valid && !in_stall) || (out_valid && !out_stall) ||
                   (cfg_valid && cfg_ready);
    idle_cycles <= accepted_any ? 0 : idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("rgba_box_downsample_2x2 verification failed");
      $finish;
    end
  end

  initial begin
    for (int v = 0; v < 256; v++) lin_of_byte[v] = srgb_to_linear(2 * v);
    round_edge[0] = '0;
    for (int k = 1; k < 256; k++) round_edge[k] = srgb_to_linear(2 * k - 1);
    foreach (pr_row_store[i]) pr_row_store[i] = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_linear_extremes();
    test_srgb_average();
    test_odd_and_unit_sizes();
    test_size_limits();
    test_random_levels(430);
    send_gap_pct = 45;
    stall_pct = 10;
    test_random_levels(430);
    send_gap_pct = 0;
    stall_pct = 0;
    test_random_levels(430);

    settle();
    if (errors == 0 && expected_texels.size() == 0)
      $display("rgba_box_downsample_2x2 verification clean");
    else
      $display("rgba_box_downsample_2x2 verification failed");
    $finish;
  end

endmodule

FILE: files.f
+incdir+sv
sv/rbd_pkg.sv
sv/rbd_row_store.sv
sv/rbd_raster.sv
sv/rbd_filter.sv
sv/rgba_box_downsample_2x2.sv
test/tb.sv
